// File: design/assert_macros.svh
// Assertion macros shared by the transform RTL.
// Depends on nothing; files that assert include it by its bare name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside of reset.
`define STTR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that must never be true outside of reset.
`define STTR_NEVER(lbl, cond, msg) \
  `STTR_ASSERT(lbl, !(cond), msg)

`endif

// File: design/sttr_pkg.sv
// Shared constants and types for the radix-4 sum-to-one transform.
// No dependencies; imported by the core.
`default_nettype none

package sttr_pkg;

  localparam int LEVELS_DEF = 3;
  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 23;
  localparam int IDX_W      = 6;
  localparam int LVW        = 2;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_XFORM = 3'b010,
    ST_EMIT  = 3'b100
  } state_e;

endpackage

`default_nettype wire

// File: design/sum_to_one_radix4_transform_core.sv
// Radix-4 sum-to-one transform core: frame load, in-place butterflies, emit.
// Depends on sttr_pkg, sttr_ram and assert_macros.svh.
//
// Usage. Samples are taken one per transaction: a sample is accepted at a
// rising edge with start high and busy low, and stored at the next index
// of the frame of 4^LEVELS samples. The transaction that brings the last
// sample of a frame raises busy. The core then runs LEVELS butterfly passes
// over the frame memory; in each pass every word is read once and written
// once through the single read port and the single write port of the
// memory, and the first write of a pass waits until the butterfly of the
// first group is complete. After that the coefficients are read out in
// index order, one per cycle, each shown for one cycle with strobe_o high;
// last_o marks the final one. busy drops in the cycle that shows the final
// coefficient, so the next frame may start there. For LEVELS = 3 a frame
// holds 64 samples. Coefficients equal the true transform times 2^LEVELS.
// The receiver cannot stall. Reset empties the partial frame and returns to
// idle; memory contents are not cleared.
`default_nettype none

`include "assert_macros.svh"

module sum_to_one_radix4_transform_core #(
  parameter int LEVELS = sttr_pkg::LEVELS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic signed [sttr_pkg::SAMPLE_W-1:0] sample_i,
  output logic                               strobe_o,
  output logic signed [sttr_pkg::COEF_W-1:0] coefficient_o,
  output logic        [sttr_pkg::IDX_W-1:0]  coef_index_o,
  output logic                               last_o
);

  import sttr_pkg::*;

  localparam int FRAME_LEN = 4 ** LEVELS;
  localparam int AW        = 2 * LEVELS;
  localparam int CW        = $clog2(FRAME_LEN + 5);
  localparam logic [CW-1:0]  T_FRAME  = CW'(FRAME_LEN);
  localparam logic [CW-1:0]  T_PASS   = CW'(FRAME_LEN + 4);
  localparam logic [CW-1:0]  T_WSTART = CW'(5);
  localparam logic [CW-1:0]  T_ONE    = CW'(1);
  localparam logic [AW-1:0]  IDX_LAST = AW'(FRAME_LEN - 1);
  localparam logic [LVW-1:0] LVL_LAST = LVW'(LEVELS - 1);

  state_e              state_q, state_d;
  logic [CW-1:0]       t_q, t_d;
  logic [LVW-1:0]      lvl_q, lvl_d;
  logic [AW-1:0]       load_cnt_q, load_cnt_d;
  logic                strobe_q, strobe_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic                last_q, last_d;

  logic [COEF_W-1:0]   p_q, q_q, r_q;
  logic [COEF_W-1:0]   o_q [4];

  logic                ram_we;
  logic [AW-1:0]       ram_waddr, ram_raddr;
  logic [COEF_W-1:0]   ram_wdata, ram_rdata;

  logic [1:0]          tm1;
  logic [AW-1:0]       wi;

  // Map the running index {group, word} of a pass to a memory address: the
  // word number goes in at bit 2*lvl, between the in-block offset and the block.
  function automatic logic [AW-1:0] grp_addr(logic [AW-1:0] i, logic [LVW-1:0] lvl);
    logic [AW-1:0] g;
    logic [AW-1:0] lo_mask;
    logic [2:0]    sh;
    sh      = {lvl, 1'b0};
    g       = i >> 2;
    lo_mask = ~({AW{1'b1}} << sh);
    return ((g & ~lo_mask) << 2) | (AW'(i[1:0]) << sh) | (g & lo_mask);
  endfunction

  assign wi  = t_q[AW-1:0] - T_WSTART[AW-1:0];
  assign tm1 = t_q[1:0] - T_ONE[1:0];

  sttr_ram #(
    .WIDTH(COEF_W),
    .DEPTH(FRAME_LEN)
  ) u_frame_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Memory port control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = load_cnt_q;
    ram_wdata = {{(COEF_W - SAMPLE_W){sample_i[SAMPLE_W-1]}}, sample_i};
    ram_raddr = t_q[AW-1:0];
    unique case (state_q)
      ST_IDLE: begin
        ram_we = start;
      end
      ST_XFORM: begin
        ram_raddr = grp_addr(t_q[AW-1:0], lvl_q);
        ram_waddr = grp_addr(wi, lvl_q);
        ram_wdata = o_q[wi[1:0]];
        ram_we    = (t_q >= T_WSTART);
      end
      ST_EMIT: begin
        ram_raddr = t_q[AW-1:0];
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  // Sequencer.
  always_comb begin
    state_d    = state_q;
    t_d        = t_q;
    lvl_d      = lvl_q;
    load_cnt_d = load_cnt_q;
    strobe_d   = 1'b0;
    idx_d      = idx_q;
    last_d     = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          load_cnt_d = load_cnt_q + AW'(1);
          if (load_cnt_q == IDX_LAST) begin
            state_d = ST_XFORM;
            t_d     = '0;
            lvl_d   = '0;
          end
        end
      end
      ST_XFORM: begin
        t_d = t_q + T_ONE;
        if (t_q == T_PASS) begin
          t_d = '0;
          if (lvl_q == LVL_LAST) begin
            state_d = ST_EMIT;
          end else begin
            lvl_d = lvl_q + LVW'(1);
          end
        end
      end
      ST_EMIT: begin
        t_d      = t_q + T_ONE;
        strobe_d = 1'b1;
        idx_d    = IDX_W'(t_q[AW-1:0]);
        last_d   = (t_q[AW-1:0] == IDX_LAST);
        if (t_q[AW-1:0] == IDX_LAST) begin
          state_d = ST_IDLE;
          t_d     = '0;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      t_q        <= '0;
      lvl_q      <= '0;
      load_cnt_q <= '0;
      strobe_q   <= 1'b0;
      idx_q      <= '0;
      last_q     <= 1'b0;
    end else begin
      state_q    <= state_d;
      t_q        <= t_d;
      lvl_q      <= lvl_d;
      load_cnt_q <= load_cnt_d;
      strobe_q   <= strobe_d;
      idx_q      <= idx_d;
      last_q     <= last_d;
    end
  end

  // Read data for word t-1 arrives now; the fourth word of a group completes
  // the butterfly, whose results are registered in o_q and then written back word by word.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_XFORM && t_q >= T_ONE && t_q <= T_FRAME) begin
      case (tm1)
        2'd0: p_q <= ram_rdata;
        2'd1: q_q <= ram_rdata;
        2'd2: r_q <= ram_rdata;
        default: begin
          o_q[0] <= p_q + q_q + r_q - ram_rdata;
          o_q[1] <= p_q + q_q - r_q + ram_rdata;
          o_q[2] <= p_q - q_q + r_q + ram_rdata;
          o_q[3] <= q_q + r_q + ram_rdata - p_q;
        end
      endcase
    end
  end

  assign busy          = (state_q != ST_IDLE);
  assign strobe_o      = strobe_q;
  assign coefficient_o = ram_rdata;
  assign coef_index_o  = idx_q;
  assign last_o        = last_q;

  `STTR_ASSERT(a_strobe_after_emit, strobe_o |-> $past(state_q == ST_EMIT),
               "result strobe without a preceding emit cycle")
  `STTR_ASSERT(a_last_at_end, last_o |-> (strobe_o && coef_index_o == IDX_W'(IDX_LAST)),
               "last flag away from the final coefficient")
  `STTR_NEVER(a_no_write_in_emit, ram_we && state_q == ST_EMIT,
              "frame memory written during readout")
  `STTR_ASSERT(a_pass_starts_clean, $rose(state_q == ST_XFORM) |-> (t_q == '0 && lvl_q == '0),
               "transform entered with stale pass counters")
  `STTR_ASSERT(a_load_count_idle, (state_q != ST_IDLE) |-> (load_cnt_q == '0),
               "partial frame count while busy")

endmodule

`default_nettype wire

// File: design/sttr_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`default_nettype none

module sttr_ram #(
  parameter int WIDTH = 23,
  parameter int DEPTH = 64,
  localparam int AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire
